[rtl/sket_pkg.sv]
// shared types and codes for the sorted keyed entry table
package sket_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_RESULTS  = 64;

    localparam logic [2:0] REQ_SET    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] player_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [63:0] update_tick;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [5:0]  entry_index;
        logic [31:0] out_id;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [63:0] out_tick;
        logic [6:0]  entry_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [63:0] tick;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_MOVE,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

endpackage

[rtl/sorted_keyed_entry_table_core.sv]
// sorted keyed entry table: controller, search, shift and result register
// Holds up to CAPACITY entries in ascending key order in one entry memory (one write port,
// one registered read port). A set, remove or lookup first runs a binary search over the
// held entries, each step a read of the middle entry and then a compare; an insert then
// moves every entry from its slot up by one place, and a remove every entry above the hit
// down by one place, one entry at a time, bounded by the single memory write port. A dump
// emits each entry in key order, each beat a memory read and then the result register, at
// most 64 beats, the final one flagged last. A finished result sits in the output register
// so the next request can be accepted while it waits; a new request is taken only once the
// previous one has fully left the controller. Unknown request codes are dropped without a
// result. No clearing pass is needed after reset.
module sorted_keyed_entry_table_core #(
    parameter int CAPACITY = sket_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sket_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sket_pkg::t_out o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    sket_pkg::t_state r_state, n_state;
    sket_pkg::t_in    r_req;
    sket_pkg::t_entry r_ent;
    sket_pkg::t_out   r_out_data;
    logic             r_out_valid;
    logic [CW-1:0]    r_occ;
    logic [CW-1:0]    r_lo, r_hi, r_left;
    logic [IW-1:0]    r_mid, r_pos, r_src, r_dst;
    logic             r_found, r_wpend, r_up, r_have;
    logic [1:0]       r_status;

    logic             mem_wr_en, mem_rd_en;
    logic [IW-1:0]    mem_wr_addr, mem_rd_addr;
    sket_pkg::t_entry mem_wr_data, mem_rd_data;

    logic             in_fire, out_free, out_load;
    sket_pkg::t_out   out_next;
    logic [CW:0]      mid_sum;
    logic [IW-1:0]    mid;
    logic             srch_done, is_set, full, key_lt, key_eq, move_done, dump_last;
    logic [CW-1:0]    occ_m1, lo_p1;
    logic [31:0]      dump_n;
    sket_pkg::t_entry new_ent;

    function automatic sket_pkg::t_out f_result(input logic [1:0] status,
                                                input logic have,
                                                input logic [31:0] idx,
                                                input sket_pkg::t_entry ent,
                                                input logic [31:0] cnt,
                                                input logic last);
        sket_pkg::t_out res;
        res.status      = status;
        res.entry_valid = have;
        res.entry_index = have ? idx[5:0] : 6'd0;
        res.out_id      = have ? ent.key : 32'd0;
        res.out_x       = have ? ent.pos_x : 32'd0;
        res.out_y       = have ? ent.pos_y : 32'd0;
        res.out_z       = have ? ent.pos_z : 32'd0;
        res.out_tick    = have ? ent.tick : 64'd0;
        res.entry_count = cnt[6:0];
        res.last        = last;
        return res;
    endfunction

    sket_mem #(
        .DEPTH(CAPACITY),
        .AW   (IW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_wr_addr),
        .i_wr_data(mem_wr_data),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_rd_data)
    );

    assign o_in_ready  = (r_state == sket_pkg::S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[IW:1];
    assign srch_done = (r_lo >= r_hi);
    assign is_set    = (r_req.req_type == sket_pkg::REQ_SET);
    assign full      = (r_occ == CW'(CAPACITY));
    assign key_lt    = (mem_rd_data.key < r_req.player_id);
    assign key_eq    = (mem_rd_data.key == r_req.player_id);
    assign move_done = (r_left == '0) && !r_wpend;
    assign occ_m1    = r_occ - CW'(1);
    assign lo_p1     = r_lo + CW'(1);
    assign dump_n    = (32'(r_occ) < 32'(sket_pkg::MAX_RESULTS)) ? 32'(r_occ)
                                                                 : 32'(sket_pkg::MAX_RESULTS);
    assign dump_last = ((32'(r_src) + 32'd1) == dump_n);
    assign new_ent   = '{key: r_req.player_id, pos_x: r_req.pos_x, pos_y: r_req.pos_y,
                         pos_z: r_req.pos_z, tick: r_req.update_tick};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sket_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.req_type)
                        sket_pkg::REQ_SET: begin
                            n_state = (i_in_data.player_id == 32'd0) ? sket_pkg::S_RESP
                                                                     : sket_pkg::S_SRCH;
                        end
                        sket_pkg::REQ_REMOVE, sket_pkg::REQ_LOOKUP: begin
                            n_state = sket_pkg::S_SRCH;
                        end
                        sket_pkg::REQ_CLEAR: begin
                            n_state = sket_pkg::S_RESP;
                        end
                        sket_pkg::REQ_DUMP: begin
                            n_state = (r_occ == '0) ? sket_pkg::S_RESP : sket_pkg::S_DUMP_RD;
                        end
                        default: begin
                            n_state = sket_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sket_pkg::S_SRCH: begin
                if (!srch_done) begin
                    n_state = sket_pkg::S_CMP;
                end else if (is_set) begin
                    n_state = (r_found || full) ? sket_pkg::S_RESP : sket_pkg::S_MOVE;
                end else if (r_found && r_req.req_type == sket_pkg::REQ_REMOVE) begin
                    n_state = sket_pkg::S_MOVE;
                end else begin
                    n_state = sket_pkg::S_RESP;
                end
            end
            sket_pkg::S_CMP: begin
                n_state = sket_pkg::S_SRCH;
            end
            sket_pkg::S_MOVE: begin
                if (move_done) begin
                    n_state = sket_pkg::S_RESP;
                end
            end
            sket_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = sket_pkg::S_IDLE;
                end
            end
            sket_pkg::S_DUMP_RD: begin
                n_state = sket_pkg::S_DUMP_OUT;
            end
            sket_pkg::S_DUMP_OUT: begin
                if (out_free) begin
                    n_state = dump_last ? sket_pkg::S_IDLE : sket_pkg::S_DUMP_RD;
                end
            end
            default: begin
                n_state = sket_pkg::S_IDLE;
            end
        endcase
    end

    // memory and result register controls
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_src;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = new_ent;
        out_load    = 1'b0;
        out_next    = f_result(r_status, r_have, 32'(r_pos), r_ent, 32'(r_occ), 1'b1);
        case (r_state)
            sket_pkg::S_SRCH: begin
                if (!srch_done) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid;
                end else if (is_set && r_found) begin
                    // update in place
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_lo[IW-1:0];
                end
            end
            sket_pkg::S_MOVE: begin
                mem_rd_en = (r_left != '0);
                if (r_wpend) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_dst;
                    mem_wr_data = mem_rd_data;
                end else if (move_done && r_up) begin
                    // gap is open, drop the new entry in
                    mem_wr_en = 1'b1;
                end
            end
            sket_pkg::S_RESP: begin
                out_load = out_free;
            end
            sket_pkg::S_DUMP_RD: begin
                mem_rd_en = 1'b1;
            end
            sket_pkg::S_DUMP_OUT: begin
                out_load = out_free;
                out_next = f_result(sket_pkg::STAT_OK, 1'b1, 32'(r_src), mem_rd_data,
                                    32'(r_occ), dump_last);
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sket_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && i_in_data.req_type == sket_pkg::REQ_CLEAR) begin
                r_occ <= '0;
            end else if (r_state == sket_pkg::S_MOVE && move_done) begin
                r_occ <= r_up ? r_occ + CW'(1) : occ_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_next;
        end
        case (r_state)
            sket_pkg::S_IDLE: begin
                if (in_fire) begin
                    r_req    <= i_in_data;
                    r_lo     <= '0;
                    r_hi     <= r_occ;
                    r_found  <= 1'b0;
                    r_src    <= '0;
                    r_pos    <= '0;
                    r_have   <= 1'b0;
                    r_status <= (i_in_data.req_type == sket_pkg::REQ_SET &&
                                 i_in_data.player_id == 32'd0) ? sket_pkg::STAT_ZERO
                                                               : sket_pkg::STAT_OK;
                end
            end
            sket_pkg::S_SRCH: begin
                if (!srch_done) begin
                    r_mid <= mid;
                end else begin
                    r_pos   <= r_lo[IW-1:0];
                    r_wpend <= 1'b0;
                    if (is_set) begin
                        r_ent <= new_ent;
                        if (!r_found && full) begin
                            r_status <= sket_pkg::STAT_FULL;
                            r_have   <= 1'b0;
                        end else begin
                            r_status <= sket_pkg::STAT_OK;
                            r_have   <= 1'b1;
                        end
                        // insert: move entries lo..occ-1 up, top first
                        r_up   <= 1'b1;
                        r_src  <= occ_m1[IW-1:0];
                        r_left <= r_occ - r_lo;
                    end else begin
                        r_status <= r_found ? sket_pkg::STAT_OK : sket_pkg::STAT_NOTFOUND;
                        r_have   <= r_found;
                        // remove: move entries lo+1..occ-1 down, bottom first
                        r_up   <= 1'b0;
                        r_src  <= lo_p1[IW-1:0];
                        r_left <= occ_m1 - r_lo;
                    end
                end
            end
            sket_pkg::S_CMP: begin
                if (key_lt) begin
                    r_lo <= CW'(r_mid) + CW'(1);
                end else begin
                    r_hi <= CW'(r_mid);
                end
                if (key_eq) begin
                    r_found <= 1'b1;
                    r_ent   <= mem_rd_data;
                end
            end
            sket_pkg::S_MOVE: begin
                r_wpend <= (r_left != '0);
                if (r_left != '0) begin
                    r_src  <= r_up ? r_src - IW'(1) : r_src + IW'(1);
                    r_dst  <= r_up ? r_src + IW'(1) : r_src - IW'(1);
                    r_left <= r_left - CW'(1);
                end
            end
            sket_pkg::S_DUMP_OUT: begin
                if (out_free && !dump_last) begin
                    r_src <= r_src + IW'(1);
                end
            end
            default: begin
                r_wpend <= r_wpend;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_srch_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sket_pkg::S_SRCH || r_state == sket_pkg::S_CMP) |-> r_lo <= r_hi)
        else $error("search window inverted");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> CW'(mem_wr_addr) <= r_occ)
        else $error("write beyond held entries");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sket_pkg::S_MOVE && move_done && r_up) |=>
            r_occ == $past(r_occ) + CW'(1))
        else $error("insert did not grow table by one");

    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sket_pkg::S_DUMP_RD || r_state == sket_pkg::S_DUMP_OUT) |-> r_occ != '0)
        else $error("dump beat from empty table");
`endif

endmodule

[rtl/sket_mem.sv]
// entry memory: one write port, one registered read port
module sket_mem #(
    parameter int DEPTH = sket_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  sket_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output sket_pkg::t_entry o_rd_data
);

    sket_pkg::t_entry r_mem [DEPTH];
    sket_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[tb/sorted_keyed_entry_table_core_tb.sv]
// self-checking testbench: directed and random requests checked against a behavioral table mirror
`timescale 1ns / 1ps

module sorted_keyed_entry_table_core_tb;

    localparam int unsigned CAPACITY    = sket_pkg::CAPACITY_DEF;
    localparam int unsigned KEY_POOL    = 66;
    localparam int unsigned MIXED_ITEMS = 110;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // request codes the block drops without a result
    localparam logic [2:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNDEF_LAST  = 3'd7;

    typedef struct {
        sket_pkg::t_in  req;
        bit             typed;
        sket_pkg::t_out want;
    } t_stim_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    sket_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    sket_pkg::t_out o_out_data;

    sket_pkg::t_entry entry_mirror [CAPACITY];
    int unsigned      mirror_count;
    sket_pkg::t_out   fresh_replies [$];
    sket_pkg::t_out   awaited_replies [$];
    t_stim_row        directed_rows [$];
    logic [31:0]      key_pool [KEY_POOL];
    int unsigned      error_count;
    int unsigned      cycle_count;
    bit               hold_off_req;
    sket_pkg::t_out   head_reply;

    sorted_keyed_entry_table_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic sket_pkg::t_in mk_req(logic [2:0] op, logic [31:0] key, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [63:0] tick);
        sket_pkg::t_in r;
        r.req_type    = op;
        r.player_id   = key;
        r.pos_x       = x;
        r.pos_y       = y;
        r.pos_z       = z;
        r.update_tick = tick;
        return r;
    endfunction

    // entry fields read as zero whenever no entry is carried
    function automatic sket_pkg::t_out make_reply(logic [1:0] st, bit have, logic [5:0] idx,
                                                  logic [31:0] key, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z,
                                                  logic [63:0] tick, logic [6:0] cnt,
                                                  bit fin);
        sket_pkg::t_out o;
        o.status      = st;
        o.entry_valid = have;
        o.entry_index = have ? idx : '0;
        o.out_id      = have ? key : '0;
        o.out_x       = have ? x : '0;
        o.out_y       = have ? y : '0;
        o.out_z       = have ? z : '0;
        o.out_tick    = have ? tick : '0;
        o.entry_count = cnt;
        o.last        = fin;
        return o;
    endfunction

    function automatic sket_pkg::t_out entry_reply(sket_pkg::t_entry e, int unsigned idx,
                                                   bit fin);
        return make_reply(sket_pkg::STAT_OK, 1'b1, idx[5:0], e.key, e.pos_x, e.pos_y, e.pos_z,
                          e.tick, mirror_count[6:0], fin);
    endfunction

    // applies one request to the mirror and queues the beats it should produce
    task automatic compute_replies(input sket_pkg::t_in r);
        int unsigned      slot;
        int unsigned      i;
        int unsigned      n;
        bit               hit;
        sket_pkg::t_entry e;
        slot = 0;
        while (slot < mirror_count && entry_mirror[slot].key < r.player_id)
            slot++;
        hit = (slot < mirror_count) && (entry_mirror[slot].key == r.player_id);
        case (r.req_type)
            sket_pkg::REQ_SET: begin
                if (r.player_id == '0) begin
                    fresh_replies.push_back(make_reply(sket_pkg::STAT_ZERO, 1'b0, '0, '0, '0,
                                                       '0, '0, '0, mirror_count[6:0], 1'b1));
                end else if (!hit && mirror_count >= CAPACITY) begin
                    fresh_replies.push_back(make_reply(sket_pkg::STAT_FULL, 1'b0, '0, '0, '0,
                                                       '0, '0, '0, mirror_count[6:0], 1'b1));
                end else begin
                    if (!hit) begin
                        for (i = mirror_count; i > slot; i--)
                            entry_mirror[i] = entry_mirror[i - 1];
                        mirror_count++;
                    end
                    e.key   = r.player_id;
                    e.pos_x = r.pos_x;
                    e.pos_y = r.pos_y;
                    e.pos_z = r.pos_z;
                    e.tick  = r.update_tick;
                    entry_mirror[slot] = e;
                    fresh_replies.push_back(entry_reply(e, slot, 1'b1));
                end
            end
            sket_pkg::REQ_REMOVE, sket_pkg::REQ_LOOKUP: begin
                if (!hit) begin
                    fresh_replies.push_back(make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0,
                                                       '0, '0, '0, '0, mirror_count[6:0],
                                                       1'b1));
                end else begin
                    e = entry_mirror[slot];
                    if (r.req_type == sket_pkg::REQ_REMOVE) begin
                        for (i = slot; i + 1 < mirror_count; i++)
                            entry_mirror[i] = entry_mirror[i + 1];
                        mirror_count--;
                    end
                    fresh_replies.push_back(entry_reply(e, slot, 1'b1));
                end
            end
            sket_pkg::REQ_CLEAR: begin
                mirror_count = 0;
                fresh_replies.push_back(make_reply(sket_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0,
                                                   '0, '0, 1'b1));
            end
            sket_pkg::REQ_DUMP: begin
                n = (mirror_count < sket_pkg::MAX_RESULTS) ? mirror_count
                                                           : sket_pkg::MAX_RESULTS;
                if (n == 0) begin
                    fresh_replies.push_back(make_reply(sket_pkg::STAT_OK, 1'b0, '0, '0, '0,
                                                       '0, '0, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < n; i++)
                        fresh_replies.push_back(entry_reply(entry_mirror[i], i, i + 1 == n));
                end
            end
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 76)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        if (roll < 82)
            return '0;
        return $urandom;
    endfunction

    function automatic sket_pkg::t_in mixed_request();
        int unsigned roll;
        logic [2:0]  op;
        roll = $urandom_range(0, 99);
        if (roll < 44)
            op = sket_pkg::REQ_SET;
        else if (roll < 64)
            op = sket_pkg::REQ_REMOVE;
        else if (roll < 84)
            op = sket_pkg::REQ_LOOKUP;
        else if (roll < 90)
            op = sket_pkg::REQ_DUMP;
        else if (roll < 93)
            op = sket_pkg::REQ_CLEAR;
        else
            op = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
        return mk_req(op, pick_key(), $urandom, $urandom, $urandom, {$urandom, $urandom});
    endfunction

    task automatic add_row(input sket_pkg::t_in r, input bit typed, input sket_pkg::t_out want);
        t_stim_row row;
        row.req   = r;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // offers one beat after a random gap and records what it should produce once taken
    task automatic send_request(input sket_pkg::t_in r, input bit typed,
                                input sket_pkg::t_out want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        compute_replies(r);
        if (typed) begin
            fresh_replies.delete();
            awaited_replies.push_back(want);
        end else begin
            while (fresh_replies.size() != 0)
                awaited_replies.push_back(fresh_replies.pop_front());
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    initial begin : stimulus
        sket_pkg::t_in  r;
        sket_pkg::t_out none;
        int unsigned    order [KEY_POOL];
        int unsigned    i;
        int unsigned    j;
        int unsigned    tmp;
        int unsigned    counted;
        bit             dup;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        hold_off_req = 1'b0;
        mirror_count = 0;
        error_count  = 0;
        none         = '0;

        // distinct nonzero keys, with both key extremes among them
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < KEY_POOL; i++) begin
            do begin
                key_pool[i] = $urandom;
                dup = (key_pool[i] == '0);
                for (j = 0; j < i; j++)
                    if (key_pool[j] == key_pool[i])
                        dup = 1'b1;
            end while (dup);
        end

        add_row(mk_req(sket_pkg::REQ_DUMP, '0, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_LOOKUP, 32'd5, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_REMOVE, '0, '1, '1, '1, '1), 1'b1,
                make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, '0, '1, '1, '1, '1), 1'b1,
                make_reply(sket_pkg::STAT_ZERO, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, 32'hFFFF_FFFF, '1, '1, '1, '1), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b1, 6'd0, 32'hFFFF_FFFF, '1, '1, '1, '1, 7'd1,
                           1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, 32'd1, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b1, 6'd0, 32'd1, '0, '0, '0, '0, 7'd2, 1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, 32'd1000, 32'h1234_5678, 32'h8000_0000,
                       32'h0000_0001, 64'h0123_4567_89AB_CDEF), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_SET, 32'd1000, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 64'h8000_0000_0000_0001), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_LOOKUP, 32'd1, '1, '1, '1, '1), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b1, 6'd0, 32'd1, '0, '0, '0, '0, 7'd3, 1'b1));
        add_row(mk_req(sket_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b1, 6'd2, 32'hFFFF_FFFF, '1, '1, '1, '1, 7'd3,
                           1'b1));
        add_row(mk_req(sket_pkg::REQ_LOOKUP, 32'd999, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, '0, 7'd3, 1'b1));
        add_row(mk_req(REQ_UNDEF_FIRST, 32'd1, '1, '1, '1, '1), 1'b0, none);
        add_row(mk_req(REQ_UNDEF_FIRST + 3'd1, 32'd1000, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(REQ_UNDEF_LAST, 32'hFFFF_FFFF, '1, '0, '1, '0), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_DUMP, '0, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_REMOVE, 32'd1000, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_REMOVE, 32'd1000, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, '0, 7'd2, 1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, 32'h8000_0000, 32'hAAAA_5555, 32'h5555_AAAA,
                       32'h0000_FFFF, 64'hFFFF_0000_FFFF_0000), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_REMOVE, 32'hFFFF_FFFF, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_CLEAR, '0, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_DUMP, '0, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0, '0, 7'd0, 1'b1));
        add_row(mk_req(sket_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                       32'hFFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF), 1'b0, none);
        add_row(mk_req(sket_pkg::REQ_LOOKUP, '0, '0, '0, '0, '0), 1'b1,
                make_reply(sket_pkg::STAT_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, '0, 7'd1, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

        // fill the table in random key order; the two keys past capacity hit the full error
        for (i = 0; i < KEY_POOL; i++)
            order[i] = i;
        for (i = KEY_POOL - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_request(mk_req(sket_pkg::REQ_CLEAR, '0, '0, '0, '0, '0), 1'b0, none);
        for (i = 0; i < KEY_POOL; i++) begin
            send_request(mk_req(sket_pkg::REQ_SET, key_pool[order[i]], $urandom, $urandom,
                                $urandom, {$urandom, $urandom}), 1'b0, none);
            if ($urandom_range(0, 5) == 0)
                send_request(mk_req(sket_pkg::REQ_LOOKUP, pick_key(), $urandom, $urandom,
                                    $urandom, {$urandom, $urandom}), 1'b0, none);
            if ($urandom_range(0, 11) == 0)
                send_request(mk_req(3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST)),
                                    pick_key(), $urandom, $urandom, $urandom,
                                    {$urandom, $urandom}), 1'b0, none);
        end

        // full dump while the receiver holds off, with more requests queued behind it
        hold_off_req = 1'b1;
        send_request(mk_req(sket_pkg::REQ_DUMP, '0, '0, '0, '0, '0), 1'b0, none);
        for (i = 0; i < 4; i++)
            send_request(mk_req(sket_pkg::REQ_SET, key_pool[order[i]], $urandom, $urandom,
                                $urandom, {$urandom, $urandom}), 1'b0, none);
        send_request(mk_req(sket_pkg::REQ_SET, key_pool[order[KEY_POOL - 1]], $urandom,
                            $urandom, $urandom, {$urandom, $urandom}), 1'b0, none);
        send_request(mk_req(sket_pkg::REQ_SET, $urandom, $urandom, $urandom, $urandom,
                            {$urandom, $urandom}), 1'b0, none);

        counted = 0;
        while (counted < MIXED_ITEMS) begin
            r = mixed_request();
            send_request(r, 1'b0, none);
            if (r.req_type <= sket_pkg::REQ_DUMP)
                counted++;
        end
        send_request(mk_req(sket_pkg::REQ_DUMP, '0, '0, '0, '0, '0), 1'b0, none);

        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (error_count == 0)
            $display("sorted_keyed_entry_table_core_tb: clean");
        else
            $display("sorted_keyed_entry_table_core_tb: errors");
        $finish;
    end

    initial begin : receiver
        int unsigned burst;
        int unsigned gap;
        bit          held;
        held        = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            burst = $urandom_range(1, 24);
            gap   = pick_gap();
            i_out_ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                $error("beat with no request pending: out_id %h", o_out_data.out_id);
                error_count++;
            end else begin
                head_reply = awaited_replies.pop_front();
                check_field("status", 64'(head_reply.status), 64'(o_out_data.status));
                check_field("entry_valid", 64'(head_reply.entry_valid),
                            64'(o_out_data.entry_valid));
                check_field("entry_index", 64'(head_reply.entry_index),
                            64'(o_out_data.entry_index));
                check_field("out_id", 64'(head_reply.out_id), 64'(o_out_data.out_id));
                check_field("out_x", 64'(head_reply.out_x), 64'(o_out_data.out_x));
                check_field("out_y", 64'(head_reply.out_y), 64'(o_out_data.out_y));
                check_field("out_z", 64'(head_reply.out_z), 64'(o_out_data.out_z));
                check_field("out_tick", head_reply.out_tick, o_out_data.out_tick);
                check_field("entry_count", 64'(head_reply.entry_count),
                            64'(o_out_data.entry_count));
                check_field("last", 64'(head_reply.last), 64'(o_out_data.last));
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sorted_keyed_entry_table_core_tb: errors");
            $finish;
        end
    end

endmodule
